@@ hw/rtl/waypoint_steering_controller_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the waypoint steering controller checker.
// Both macros expect signals named clk and arst_n in the using scope.
// ---------------------------------------------------------------------------
`ifndef WAYPOINT_STEERING_CONTROLLER_MACROS_SVH
`define WAYPOINT_STEERING_CONTROLLER_MACROS_SVH

// Check that expr holds in the same cycle as cond.
`define WSC_ASSERT_SAME(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error("wsc checker: same-cycle property failed");

// Check that expr holds in the cycle after cond.
`define WSC_ASSERT_NEXT(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error("wsc checker: next-cycle property failed");

`endif

@@ hw/rtl/wsc_pkg.sv @@
// ---------------------------------------------------------------------------
// wsc_pkg
// Shared types, codes and constants of the waypoint steering controller.
// ---------------------------------------------------------------------------
package wsc_pkg;

	// item and command codes
	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_STEP    = 1'b1;
	localparam logic CMD_DRIVE  = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	// fixed field widths
	localparam int COORD_W = 12;
	localparam int DIFF_W  = 14;
	localparam int HEAD_W  = 15;
	localparam int ROBOT_W = 8;

	// arithmetic widths and constants
	localparam int SQRT_STEPS = 20;
	localparam int XW         = 34;
	localparam int ZW         = 27;
	localparam int REL_W      = 19;
	localparam int WHL_W      = 22;
	localparam int ATAN_W     = 23;

	// job handed from front to back
	typedef struct packed {
		logic                     finished;
		logic [ROBOT_W-1:0]       robot;
		logic signed [HEAD_W-1:0] heading;
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] dy;
	} job_t;

	// completion report from back to front
	typedef struct packed {
		logic done;
		logic advance;
	} back_status_t;

	// one result item
	typedef struct packed {
		logic [ROBOT_W-1:0] robot;
		logic               kind;
		logic [7:0]         sx;
		logic [7:0]         sy;
		logic               last;
	} result_t;

	// arctangent of 2^-i in 1/65536 degree
	function automatic logic [ATAN_W-1:0] atan_entry(input logic [4:0] idx);
		logic [ATAN_W-1:0] v;
		case (idx)
			5'd0:    v = 23'd2949120;
			5'd1:    v = 23'd1740967;
			5'd2:    v = 23'd919879;
			5'd3:    v = 23'd466945;
			5'd4:    v = 23'd234379;
			5'd5:    v = 23'd117304;
			5'd6:    v = 23'd58665;
			5'd7:    v = 23'd29335;
			5'd8:    v = 23'd14668;
			5'd9:    v = 23'd7334;
			5'd10:   v = 23'd3667;
			5'd11:   v = 23'd1833;
			5'd12:   v = 23'd917;
			5'd13:   v = 23'd458;
			5'd14:   v = 23'd229;
			5'd15:   v = 23'd115;
			5'd16:   v = 23'd57;
			5'd17:   v = 23'd29;
			5'd18:   v = 23'd14;
			5'd19:   v = 23'd7;
			5'd20:   v = 23'd4;
			5'd21:   v = 23'd2;
			5'd22:   v = 23'd1;
			default: v = 23'd0;
		endcase
		return v;
	endfunction

endpackage

@@ hw/rtl/wsc_ram.sv @@
// ---------------------------------------------------------------------------
// wsc_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module wsc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hw/rtl/wsc_front.sv @@
// ---------------------------------------------------------------------------
// wsc_front
// Accepts items, keeps the path and position, and turns each step into a job.
// ---------------------------------------------------------------------------
module wsc_front import wsc_pkg::*; #(
	parameter int MAX_WAYPOINTS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     opcode,
	input  logic                     path_start,
	input  logic signed [12:0]       point_x,
	input  logic signed [12:0]       point_y,
	input  logic signed [HEAD_W-1:0] heading,
	input  logic [ROBOT_W-1:0]       robot_number,
	input  back_status_t             status,
	output logic                     push_valid,
	input  logic                     push_ready,
	output job_t                     push_job
);

	localparam int AW = $clog2(MAX_WAYPOINTS);
	localparam int LW = $clog2(MAX_WAYPOINTS + 1);

	logic [LW-1:0]          len_q, tidx_q, len_eff;
	logic signed [12:0]     pos_x_q, pos_y_q;
	logic                   busy_q, pend_s1;
	logic [ROBOT_W-1:0]     robot_s1;
	logic signed [HEAD_W-1:0] heading_s1;
	logic                   accept, load, step, we;
	logic [2*COORD_W-1:0]   wdata, rdata;
	logic [COORD_W-1:0]     wp_x, wp_y;

	assign accept  = in_valid && !busy_q;
	assign load    = accept && (opcode == OP_LOAD);
	assign step    = accept && (opcode == OP_STEP);
	assign in_stall = busy_q;

	// clamp negative waypoint coordinates to zero
	assign wp_x  = point_x[12] ? '0 : point_x[COORD_W-1:0];
	assign wp_y  = point_y[12] ? '0 : point_y[COORD_W-1:0];
	assign wdata = {wp_x, wp_y};
	assign len_eff = path_start ? '0 : len_q;
	assign we      = load && (len_eff < LW'(MAX_WAYPOINTS));

	wsc_ram #(.WIDTH(2*COORD_W), .DEPTH(MAX_WAYPOINTS)) u_path (
		.clk   (clk),
		.we    (we),
		.waddr (len_eff[AW-1:0]),
		.wdata (wdata),
		.raddr (tidx_q[AW-1:0]),
		.rdata (rdata)
	);

	// path bookkeeping, position and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			tidx_q  <= '0;
			pos_x_q <= '0;
			pos_y_q <= '0;
			busy_q  <= 1'b0;
			pend_s1 <= 1'b0;
		end else begin
			if (load) begin
				if (we) begin
					len_q <= len_eff + LW'(1);
				end else begin
					len_q <= len_eff;
				end
				if (path_start) begin
					tidx_q <= '0;
				end
			end
			if (status.advance) begin
				tidx_q <= tidx_q + LW'(1);
			end
			if (step) begin
				if (!(point_x == -13'sd1 && point_y == -13'sd1)) begin
					pos_x_q <= point_x;
					pos_y_q <= point_y;
				end
				busy_q  <= 1'b1;
				pend_s1 <= 1'b1;
			end else if (status.done) begin
				busy_q <= 1'b0;
			end
			if (push_valid && push_ready) begin
				pend_s1 <= 1'b0;
			end
		end
	end

	// hold step payload for the job
	always_ff @(posedge clk) begin
		if (step) begin
			robot_s1   <= robot_number;
			heading_s1 <= heading;
		end
	end

	// build the job from the waypoint read
	assign push_valid       = pend_s1;
	assign push_job.finished = (tidx_q >= len_q);
	assign push_job.robot    = robot_s1;
	assign push_job.heading  = heading_s1;
	assign push_job.dx = $signed({2'b00, rdata[2*COORD_W-1:COORD_W]})
		- $signed({pos_x_q[12], pos_x_q});
	assign push_job.dy = $signed({2'b00, rdata[COORD_W-1:0]})
		- $signed({pos_y_q[12], pos_y_q});

endmodule

@@ hw/rtl/wsc_queue.sv @@
// ---------------------------------------------------------------------------
// wsc_queue
// Two-entry job queue between front and back.
// ---------------------------------------------------------------------------
module wsc_queue import wsc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  job_t push_job,
	output logic pop_valid,
	input  logic pop,
	output job_t pop_job
);

	job_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push, do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_job    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

@@ hw/rtl/wsc_back.sv @@
// ---------------------------------------------------------------------------
// wsc_back
// Carries out jobs: distance, bearing by CORDIC, wheel speeds, result items.
// ---------------------------------------------------------------------------
module wsc_back import wsc_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [COORD_W-1:0] threshold,
	input  logic               pop_valid,
	output logic               pop,
	input  job_t               pop_job,
	output back_status_t       status,
	output logic               out_valid,
	input  logic               out_stall,
	output result_t            result
);

	localparam int NSTEP = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;
	localparam int CW    = $clog2(NSTEP + 1);
	localparam logic [16:0] RECIP3 = 17'd43691;

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b00000000001,
		ST_MUL   = 11'b00000000010,
		ST_SUM   = 11'b00000000100,
		ST_INIT  = 11'b00000001000,
		ST_RUN   = 11'b00000010000,
		ST_POST  = 11'b00000100000,
		ST_DIV   = 11'b00001000000,
		ST_WHEEL = 11'b00010000000,
		ST_DRV   = 11'b00100000000,
		ST_FIN0  = 11'b01000000000,
		ST_FIN1  = 11'b10000000000
	} state_t;

	state_t                 state_q;
	job_t                   job_q;
	logic [25:0]            sqx_q, sqy_q;
	logic [23:0]            thr2_q;
	logic [26:0]            d2_q;
	logic signed [XW-1:0]   x_q, y_q;
	logic signed [ZW-1:0]   z_q;
	logic                   zero_q, reached_q;
	logic [39:0]            n_q;
	logic [22:0]            rem_q;
	logic [SQRT_STEPS-1:0]  root_q;
	logic [CW-1:0]          cnt_q;
	logic signed [REL_W-1:0] rel_q;
	logic [14:0]            s_q;
	logic [33:0]            prod_q;
	logic [7:0]             sx_q, sy_q;
	logic                   out_free;

	logic signed [27:0]     sqx_c, sqy_c;
	logic signed [DIFF_W:0] vx, vy;
	logic signed [XW-1:0]   x0, y0, xs, ys;
	logic signed [ZW-1:0]   zt, atan_z;
	logic [22:0]            rem_sh, trial;
	logic signed [REL_W-1:0] rel_c;
	logic [22:0]            s5;
	logic [19:0]            s_raw;
	logic [REL_W-1:0]       mag;
	logic [16:0]            two_mag;
	logic [33:0]            prod_c;
	logic signed [WHL_W-1:0] s22, rel22, third, wx, wy;

	assign out_free = !out_valid || !out_stall;
	assign pop      = (state_q == ST_IDLE) && pop_valid;

	// report the final result of a job
	always_comb begin
		status.done    = 1'b0;
		status.advance = 1'b0;
		case (state_q)
			ST_DRV: begin
				status.done    = out_free;
				status.advance = out_free && reached_q;
			end
			ST_FIN1: status.done = out_free;
			default: ;
		endcase
	end

	// squares and the CORDIC start vector
	assign sqx_c = job_q.dx * job_q.dx;
	assign sqy_c = job_q.dy * job_q.dy;
	assign vx    = -$signed({job_q.dx[DIFF_W-1], job_q.dx});
	assign vy    = -$signed({job_q.dy[DIFF_W-1], job_q.dy});
	assign x0    = XW'(vx) <<< 16;
	assign y0    = XW'(vy) <<< 16;

	// one CORDIC micro-rotation and one root digit
	assign xs     = x_q >>> cnt_q;
	assign ys     = y_q >>> cnt_q;
	assign atan_z = $signed(ZW'(atan_entry(5'(cnt_q))));
	assign rem_sh = {rem_q[20:0], n_q[39:38]};
	assign trial  = {1'b0, root_q, 2'b01};

	// bearing, relative yaw wrap and speed scale
	always_comb begin
		if (zero_q) begin
			zt = '0;
		end else if (z_q < 0) begin
			zt = -((-z_q) >>> 10);
		end else begin
			zt = z_q >>> 10;
		end
		rel_c = REL_W'(zt) - REL_W'(job_q.heading);
		if (rel_c < -19'sd5760) begin
			rel_c = rel_c + 19'sd23040;
		end
		if (rel_c > 19'sd11520) begin
			rel_c = rel_c - 19'sd23040;
		end
		if (rel_c < -19'sd11520) begin
			rel_c = rel_c + 19'sd23040;
		end
		s5    = {3'b000, root_q} + {1'b0, root_q, 2'b00};
		s_raw = s5[22:3];
	end

	// two thirds of the relative yaw through a reciprocal
	assign mag     = rel_q[REL_W-1] ? REL_W'(-rel_q) : REL_W'(rel_q);
	assign two_mag = {mag[15:0], 1'b0};
	assign prod_c  = two_mag * RECIP3;

	// wheel speeds with dead band and floors
	always_comb begin
		s22   = $signed({7'b0, s_q});
		rel22 = WHL_W'(rel_q);
		third = rel_q[REL_W-1] ? -$signed({5'b0, prod_q[33:17]})
			: $signed({5'b0, prod_q[33:17]});
		if (rel_q < -19'sd192) begin
			wx = s22 + (rel22 <<< 2);
			wy = s22 + third;
			if (wx < 22'sd1920) wx = 22'sd1920;
			if (wy < 22'sd2560) wy = 22'sd2560;
		end else if (rel_q > 19'sd192) begin
			wx = s22 - third;
			wy = s22 - (rel22 <<< 2);
			if (wx < 22'sd2560) wx = 22'sd2560;
			if (wy < 22'sd1920) wy = 22'sd1920;
		end else begin
			wx = (s22 < 22'sd2560) ? 22'sd2560 : s22;
			wy = wx;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
			cnt_q     <= '0;
			reached_q <= 1'b0;
		end else begin
			if (!out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						reached_q <= 1'b0;
						state_q   <= pop_job.finished ? ST_FIN0 : ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_SUM;
				ST_SUM: state_q <= ST_INIT;
				ST_INIT: begin
					cnt_q <= '0;
					if (d2_q < 27'(thr2_q)) begin
						reached_q <= 1'b1;
						state_q   <= ST_DRV;
					end else begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(NSTEP - 1)) begin
						state_q <= ST_POST;
					end
				end
				ST_POST:  state_q <= ST_DIV;
				ST_DIV:   state_q <= ST_WHEEL;
				ST_WHEEL: state_q <= ST_DRV;
				ST_DRV: begin
					if (out_free) begin
						out_valid <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				ST_FIN0: begin
					if (out_free) begin
						out_valid <= 1'b1;
						state_q   <= ST_FIN1;
					end
				end
				ST_FIN1: begin
					if (out_free) begin
						out_valid <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop_valid) begin
					job_q <= pop_job;
				end
			end
			ST_MUL: begin
				sqx_q  <= 26'(sqx_c);
				sqy_q  <= 26'(sqy_c);
				thr2_q <= threshold * threshold;
			end
			ST_SUM: d2_q <= 27'(sqx_q) + 27'(sqy_q);
			ST_INIT: begin
				zero_q <= (job_q.dx == '0) && (job_q.dy == '0);
				n_q    <= {1'b0, d2_q, 12'b0};
				rem_q  <= '0;
				root_q <= '0;
				if (vx < 0) begin
					x_q <= -x0;
					y_q <= -y0;
					z_q <= (vy >= 0) ? 27'sd11796480 : -27'sd11796480;
				end else begin
					x_q <= x0;
					y_q <= y0;
					z_q <= '0;
				end
				sx_q <= '0;
				sy_q <= '0;
			end
			ST_RUN: begin
				if (cnt_q < CW'(CORDIC_STEPS)) begin
					if (y_q >= 0) begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + atan_z;
					end else begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - atan_z;
					end
				end
				if (cnt_q < CW'(SQRT_STEPS)) begin
					n_q <= {n_q[37:0], 2'b00};
					if (rem_sh >= trial) begin
						rem_q  <= rem_sh - trial;
						root_q <= {root_q[SQRT_STEPS-2:0], 1'b1};
					end else begin
						rem_q  <= rem_sh;
						root_q <= {root_q[SQRT_STEPS-2:0], 1'b0};
					end
				end
			end
			ST_POST: begin
				rel_q <= rel_c;
				s_q   <= (s_raw > 20'd16320) ? 15'd16320 : s_raw[14:0];
			end
			ST_DIV: prod_q <= prod_c;
			ST_WHEEL: begin
				sx_q <= wx[13:6];
				sy_q <= wy[13:6];
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (out_free) begin
			case (state_q)
				ST_DRV: result <= '{robot: job_q.robot, kind: CMD_DRIVE,
					sx: sx_q, sy: sy_q, last: 1'b1};
				ST_FIN0: result <= '{robot: job_q.robot, kind: CMD_DRIVE,
					sx: 8'd0, sy: 8'd0, last: 1'b0};
				ST_FIN1: result <= '{robot: job_q.robot, kind: CMD_FINISH,
					sx: 8'd0, sy: 8'd0, last: 1'b1};
				default: ;
			endcase
		end
	end

endmodule

@@ hw/rtl/waypoint_steering_controller.sv @@
// ---------------------------------------------------------------------------
// waypoint_steering_controller
// Differential-drive waypoint follower with a stored path and CORDIC bearing.
// ---------------------------------------------------------------------------
// A load item stores a waypoint while the path has room. A step item is held
// off the input until its last result is in the output register, which an
// output stall delays. When a drive command is computed, a shared iteration
// loop runs the square root and the CORDIC side by side; a reached waypoint
// and a finished path skip that loop. The next item is taken in the cycle
// after that. The front keeps the path and position and hands each step as
// a job through a short queue to the back, which does the arithmetic and
// drives the result channel.
module waypoint_steering_controller import wsc_pkg::*; #(
	parameter int MAX_WAYPOINTS = 16,
	parameter int CORDIC_STEPS  = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [COORD_W-1:0]       cfg_wr_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     opcode,
	input  logic                     path_start,
	input  logic signed [12:0]       point_x,
	input  logic signed [12:0]       point_y,
	input  logic signed [HEAD_W-1:0] heading,
	input  logic [ROBOT_W-1:0]       robot_number,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [ROBOT_W-1:0]       target_robot,
	output logic                     command_kind,
	output logic [7:0]               speed_x,
	output logic [7:0]               speed_y,
	output logic                     last
);

	logic [COORD_W-1:0] threshold_q;
	back_status_t       status;
	logic               push_valid, push_ready, pop_valid, pop;
	job_t               push_job, pop_job;
	result_t            result;

	// proximity threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= 12'd20;
		end else if (cfg_wr_en) begin
			threshold_q <= cfg_wr_data;
		end
	end

	wsc_front #(.MAX_WAYPOINTS(MAX_WAYPOINTS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.path_start   (path_start),
		.point_x      (point_x),
		.point_y      (point_y),
		.heading      (heading),
		.robot_number (robot_number),
		.status       (status),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_job     (push_job)
	);

	wsc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_job    (pop_job)
	);

	wsc_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.threshold (threshold_q),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_job   (pop_job),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result    (result)
	);

	// unpack the result item
	assign target_robot = result.robot;
	assign command_kind = result.kind;
	assign speed_x      = result.sx;
	assign speed_y      = result.sy;
	assign last         = result.last;

endmodule

@@ hw/rtl/wsc_checker.sv @@
// ---------------------------------------------------------------------------
// wsc_checker
// Port-level checks on the result channel of the steering controller.
// ---------------------------------------------------------------------------
`include "waypoint_steering_controller_macros.svh"

module wsc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] target_robot,
	input logic       command_kind,
	input logic [7:0] speed_x,
	input logic [7:0] speed_y,
	input logic       last
);

	// hold a stalled item
	`WSC_ASSERT_NEXT(a_valid_hold, out_valid && out_stall, out_valid)
	`WSC_ASSERT_NEXT(a_payload_hold, out_valid && out_stall, $stable(target_robot) && $stable(command_kind) && $stable(speed_x) && $stable(speed_y) && $stable(last))

	// finish commands close a step and carry no speed
	`WSC_ASSERT_SAME(a_finish_form, out_valid && command_kind, last && speed_x == 8'd0 && speed_y == 8'd0)

	// only the stop ahead of a finish is not last
	`WSC_ASSERT_SAME(a_first_is_stop, out_valid && !last, !command_kind && speed_x == 8'd0 && speed_y == 8'd0)

endmodule

bind waypoint_steering_controller wsc_checker u_wsc_checker (.*);
